// ===== src/smi_pkg.sv =====
// Shared types and constants for the small matrix inverse.
// Holds item structs, the fixed-point widths and the cofactor index tables.
// Depends on nothing.
package smi_pkg;

  localparam int ELEM_W   = 24;
  localparam int CFG_W    = 2;
  localparam int OUT_W    = 32;
  localparam int N_ELEM   = 9;
  localparam int FRAC_IN  = 12;
  localparam int FRAC_OUT = 16;
  localparam int NUM_SH   = FRAC_IN + FRAC_OUT + 1;
  localparam int Q_BITS   = OUT_W + 1;
  localparam int COF_W    = 2 * ELEM_W + 1;
  localparam int DET_W    = 3 * ELEM_W + 3;
  localparam int NUM_W    = ((COF_W + NUM_SH > DET_W) ? COF_W + NUM_SH : DET_W) + 1;
  localparam int REM_W    = (NUM_W > DET_W + 1 + Q_BITS) ? NUM_W : DET_W + 1 + Q_BITS;
  localparam int N_PROD   = 2 * N_ELEM + 2;
  localparam int P_DET2_A = 2 * N_ELEM;
  localparam int P_DET2_B = 2 * N_ELEM + 1;
  localparam int N_DET    = 3;

  localparam int FRONT_STAGES    = 7;
  localparam int QUEUE_DEPTH_DEF = FRONT_STAGES + 2;

  localparam logic [CFG_W-1:0] ORDER_2X2   = 2'd2;
  localparam logic [CFG_W-1:0] ORDER_3X3   = 2'd3;
  localparam logic [CFG_W-1:0] ORDER_RESET = ORDER_3X3;

  localparam logic [Q_BITS-1:0] MAG_POS = Q_BITS'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [Q_BITS-1:0] MAG_NEG = Q_BITS'(64'd1 << (OUT_W - 1));

  // adjugate entry k = m[A]*m[B] - m[C]*m[D]
  localparam logic [3:0] COF_A [N_ELEM] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam logic [3:0] COF_B [N_ELEM] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam logic [3:0] COF_C [N_ELEM] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam logic [3:0] COF_D [N_ELEM] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_3;
    logic signed [ELEM_W-1:0] elem_4;
    logic signed [ELEM_W-1:0] elem_5;
    logic signed [ELEM_W-1:0] elem_6;
    logic signed [ELEM_W-1:0] elem_7;
    logic signed [ELEM_W-1:0] elem_8;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv_0;
    logic signed [OUT_W-1:0] inv_1;
    logic signed [OUT_W-1:0] inv_2;
    logic signed [OUT_W-1:0] inv_3;
    logic signed [OUT_W-1:0] inv_4;
    logic signed [OUT_W-1:0] inv_5;
    logic signed [OUT_W-1:0] inv_6;
    logic signed [OUT_W-1:0] inv_7;
    logic signed [OUT_W-1:0] inv_8;
    logic                    singular;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic [N_ELEM-1:0][COF_W-1:0] adj_mag;
    logic [N_ELEM-1:0]            res_neg;
    logic [DET_W-1:0]             det_mag;
    logic                         singular;
    logic [N_ELEM-1:0][OUT_W-1:0] echo;
  } work_t;

endpackage

// ===== src/smi_front.sv =====
// Front part: order register, input acceptance, cofactors and determinant.
// Classifies each matrix into magnitudes and signs for the divider queue.
// Depends on smi_pkg.
module smi_front #(
  parameter int QUEUE_DEPTH = smi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [smi_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  smi_pkg::in_item_t        in_item,
  input  logic                     q_pop,
  output logic                     push,
  output smi_pkg::work_t           push_data
);
  import smi_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [ELEM_W-1:0] elem_row_t [N_ELEM];
  typedef logic signed [COF_W-1:0]  cof_row_t  [N_ELEM];

  logic [CFG_W-1:0]        order_r;
  logic [OCC_W-1:0]        occ_r;
  logic [OCC_W-1:0]        occ_nxt;
  logic [FRONT_STAGES-1:0] v_r;
  logic                    acc;

  elem_row_t in_m;
  elem_row_t m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic      two0_r, two1_r, two2_r, two3_r, two4_r, two5_r;

  logic signed [2*ELEM_W-1:0] p_r [N_PROD];
  cof_row_t                   c_r, c3_r, c4_r;
  logic signed [COF_W-1:0]    d2x_r, d2x3_r, d2x4_r;
  logic signed [2*ELEM_W:0]   pl_r [N_DET];
  logic signed [2*ELEM_W:0]   ph_r [N_DET];
  logic signed [DET_W-1:0]    t_r [N_DET];
  logic signed [DET_W-1:0]    det_r;
  cof_row_t                   a_r;
  cof_row_t                   a_nxt;
  logic signed [DET_W-1:0]    det_nxt;
  work_t                      work_r;
  work_t                      work_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = (occ_r >= OCC_W'(QUEUE_DEPTH));
  assign acc       = in_valid && !in_stall;
  assign push      = v_r[FRONT_STAGES-1];
  assign push_data = work_r;
  assign occ_nxt   = occ_r + OCC_W'(acc) - OCC_W'(q_pop);

  always_comb begin
    in_m[0] = in_item.elem_0;
    in_m[1] = in_item.elem_1;
    in_m[2] = in_item.elem_2;
    in_m[3] = in_item.elem_3;
    in_m[4] = in_item.elem_4;
    in_m[5] = in_item.elem_5;
    in_m[6] = in_item.elem_6;
    in_m[7] = in_item.elem_7;
    in_m[8] = in_item.elem_8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
      occ_r   <= '0;
      v_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_data;
      end
      occ_r <= occ_nxt;
      v_r   <= {v_r[FRONT_STAGES-2:0], acc};
    end
  end

  always_comb begin
    det_nxt = t_r[0] + t_r[1] + t_r[2];
    a_nxt   = c4_r;
    if (two4_r) begin
      det_nxt = DET_W'(d2x4_r);
      for (int k = 0; k < N_ELEM; k++) begin
        a_nxt[k] = '0;
      end
      a_nxt[0] = COF_W'(m4_r[3]);
      a_nxt[1] = -COF_W'(m4_r[1]);
      a_nxt[2] = -COF_W'(m4_r[2]);
      a_nxt[3] = COF_W'(m4_r[0]);
    end
  end

  always_comb begin
    work_nxt.det_mag  = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    work_nxt.singular = (det_r == '0);
    for (int k = 0; k < N_ELEM; k++) begin
      work_nxt.adj_mag[k] = a_r[k][COF_W-1] ? COF_W'(-a_r[k]) : COF_W'(a_r[k]);
      work_nxt.res_neg[k] = a_r[k][COF_W-1] ^ det_r[DET_W-1];
      work_nxt.echo[k]    = (two5_r && k >= 4) ? '0 : OUT_W'(m5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    m0_r   <= in_m;
    two0_r <= (order_r == ORDER_2X2);

    for (int k = 0; k < N_ELEM; k++) begin
      p_r[2*k]   <= m0_r[COF_A[k]] * m0_r[COF_B[k]];
      p_r[2*k+1] <= m0_r[COF_C[k]] * m0_r[COF_D[k]];
    end
    p_r[P_DET2_A] <= m0_r[0] * m0_r[3];
    p_r[P_DET2_B] <= m0_r[1] * m0_r[2];
    m1_r   <= m0_r;
    two1_r <= two0_r;

    for (int k = 0; k < N_ELEM; k++) begin
      c_r[k] <= COF_W'(p_r[2*k]) - COF_W'(p_r[2*k+1]);
    end
    d2x_r  <= COF_W'(p_r[P_DET2_A]) - COF_W'(p_r[P_DET2_B]);
    m2_r   <= m1_r;
    two2_r <= two1_r;

    for (int j = 0; j < N_DET; j++) begin
      pl_r[j] <= m2_r[j] * $signed({1'b0, c_r[3*j][ELEM_W-1:0]});
      ph_r[j] <= m2_r[j] * $signed(c_r[3*j][COF_W-1:ELEM_W]);
    end
    c3_r   <= c_r;
    d2x3_r <= d2x_r;
    m3_r   <= m2_r;
    two3_r <= two2_r;

    for (int j = 0; j < N_DET; j++) begin
      t_r[j] <= (DET_W'(ph_r[j]) <<< ELEM_W) + DET_W'(pl_r[j]);
    end
    c4_r   <= c3_r;
    d2x4_r <= d2x3_r;
    m4_r   <= m3_r;
    two4_r <= two3_r;

    det_r  <= det_nxt;
    a_r    <= a_nxt;
    m5_r   <= m4_r;
    two5_r <= two4_r;

    work_r <= work_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QUEUE_DEPTH))
    else $error("front credit count above queue depth");

  a_push_credit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> occ_r != '0)
    else $error("front pushed without an outstanding credit");

endmodule

// ===== src/smi_queue.sv =====
// Short register queue between front and back parts.
// Holds classified matrices waiting for the divider pipeline.
// Depends on smi_pkg.
module smi_queue #(
  parameter int DEPTH = smi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smi_pkg::work_t push_data,
  input  logic           pop,
  output smi_pkg::work_t head,
  output logic           nonempty
);
  import smi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign head     = mem_r[rd_r];
  assign nonempty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CNT_W'(DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue read while empty");

endmodule

// ===== src/smi_div_lane.sv =====
// One lane of the back part: rounded quotient adj * 2^28 / det, one bit a stage.
// Restoring division over 33 stages, then clip to 32-bit signed.
// Depends on smi_pkg.
module smi_div_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [smi_pkg::COF_W-1:0]    adj_mag,
  input  logic                         res_neg,
  input  logic [smi_pkg::DET_W-1:0]    det_mag,
  output logic signed [smi_pkg::OUT_W-1:0] res,
  output logic                         clip
);
  import smi_pkg::*;

  logic [NUM_W-1:0]  num_r;
  logic [DET_W:0]    d2a_r;
  logic              nega_r;

  logic [REM_W-1:0]  rem_r [Q_BITS+1];
  logic [Q_BITS-1:0] q_r   [Q_BITS+1];
  logic [DET_W:0]    d2_r  [Q_BITS+1];
  logic              neg_r [Q_BITS+1];
  logic              ovf_r [Q_BITS+1];

  logic [Q_BITS-1:0] lim;
  logic [OUT_W-1:0]  mag;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= (NUM_W'(adj_mag) << NUM_SH) + NUM_W'(det_mag);
      d2a_r    <= {det_mag, 1'b0};
      nega_r   <= res_neg;
      rem_r[0] <= REM_W'(num_r);
      q_r[0]   <= '0;
      d2_r[0]  <= d2a_r;
      neg_r[0] <= nega_r;
      ovf_r[0] <= REM_W'(num_r) >= (REM_W'(d2a_r) << Q_BITS);
    end
  end

  for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
    logic [REM_W-1:0] dsh;
    logic             ge;
    assign dsh = REM_W'(d2_r[s]) << (Q_BITS - 1 - s);
    assign ge  = rem_r[s] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? rem_r[s] - dsh : rem_r[s];
        q_r[s+1]   <= {q_r[s][Q_BITS-2:0], ge};
        d2_r[s+1]  <= d2_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  always_comb begin
    lim  = neg_r[Q_BITS] ? MAG_NEG : MAG_POS;
    clip = ovf_r[Q_BITS] || (q_r[Q_BITS] > lim);
    mag  = clip ? lim[OUT_W-1:0] : q_r[Q_BITS][OUT_W-1:0];
    res  = neg_r[Q_BITS] ? -$signed(mag) : $signed(mag);
  end

endmodule

// ===== src/smi_back.sv =====
// Back part: pops the queue, runs nine divider lanes, drives the result register.
// Picks echo on singular matrices and merges the clip flags.
// Depends on smi_pkg and smi_div_lane.
module smi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  smi_pkg::work_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output smi_pkg::out_item_t out_item
);
  import smi_pkg::*;

  localparam int LAT = Q_BITS + 2;

  logic                         en;
  logic [LAT-1:0]               bv_r;
  logic                         sing_r [LAT];
  logic [N_ELEM-1:0][OUT_W-1:0] echo_r [LAT];
  logic                         out_valid_r;
  out_item_t                    out_r;
  out_item_t                    out_nxt;

  logic signed [OUT_W-1:0] res [N_ELEM];
  logic [N_ELEM-1:0]       clip;
  logic signed [OUT_W-1:0] sel [N_ELEM];

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && q_nonempty;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    smi_div_lane u_lane (
      .clk     (clk),
      .en      (en),
      .adj_mag (head.adj_mag[k]),
      .res_neg (head.res_neg[k]),
      .det_mag (head.det_mag),
      .res     (res[k]),
      .clip    (clip[k])
    );
  end

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      sel[k] = sing_r[LAT-1] ? $signed(echo_r[LAT-1][k]) : res[k];
    end
    out_nxt.inv_0     = sel[0];
    out_nxt.inv_1     = sel[1];
    out_nxt.inv_2     = sel[2];
    out_nxt.inv_3     = sel[3];
    out_nxt.inv_4     = sel[4];
    out_nxt.inv_5     = sel[5];
    out_nxt.inv_6     = sel[6];
    out_nxt.inv_7     = sel[7];
    out_nxt.inv_8     = sel[8];
    out_nxt.singular  = sing_r[LAT-1];
    out_nxt.saturated = !sing_r[LAT-1] && (|clip);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[LAT-2:0], pop};
      out_valid_r <= bv_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0] <= head.singular;
      echo_r[0] <= head.echo;
      for (int s = 1; s < LAT; s++) begin
        sing_r[s] <= sing_r[s-1];
        echo_r[s] <= echo_r[s-1];
      end
      out_r <= out_nxt;
    end
  end

  a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.singular |-> !out_r.saturated)
    else $error("singular result flagged as saturated");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(bv_r))
    else $error("divider pipeline moved while output held");

endmodule

// ===== src/small_matrix_inverse.sv =====
// Top level of the 2x2 / 3x3 fixed-point matrix inverse.
// Depends on smi_pkg, smi_front, smi_queue and smi_back.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_valid/ready    | cfg_data: matrix_order
//   in      | in        | in_valid/in_stall  | in_item: elem_0..elem_8, Q12.12
//   out     | out       | out_valid/out_stall| out_item: inv_0..inv_8 Q16.16, flags
//
// One matrix per cycle unless in_stall or out_stall; path from accepting edge to out_valid:
// 6 front stages after the input register, one queue write, 35 divider stages, output register.
// Every divider stage is its own register, so a new matrix can enter each unstalled cycle.
// Synchronous active-low reset clears valids, pointers and order (to 3x3).
// out_stall with out_valid high freezes the back part; the front runs on queue credits.
module small_matrix_inverse #(
  parameter int QUEUE_DEPTH = smi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [smi_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  smi_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output smi_pkg::out_item_t        out_item
);
  import smi_pkg::*;

  logic  push;
  work_t push_data;
  logic  pop;
  work_t head;
  logic  nonempty;

  smi_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_pop     (pop),
    .push      (push),
    .push_data (push_data)
  );

  smi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty)
  );

  smi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
